@@ design/indexed_key_set_engine_assert.svh @@
// Assertion macros shared by the indexed key set engine.
`ifndef INDEXED_KEY_SET_ENGINE_ASSERT_SVH
`define INDEXED_KEY_SET_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IKSE_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ikse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IKSE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ikse assertion failed");

`endif

@@ design/ikse_pkg.sv @@
package ikse_pkg;

   typedef enum logic [2:0] {
      KIND_PUT          = 3'd0,
      KIND_GET_INDEX    = 3'd1,
      KIND_GET_KEY      = 3'd2,
      KIND_REMOVE_INDEX = 3'd3,
      KIND_REMOVE_KEY   = 3'd4,
      KIND_FIRST        = 3'd5,
      KIND_NEXT         = 3'd6,
      KIND_ROUND_ROBIN  = 3'd7
   } kind_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam int INDEX_WIDTH = 32;
   localparam int KEY_PORT_WIDTH = 32;

   typedef struct packed {
      logic                      key_hit;
      logic [INDEX_WIDTH-1:0]    key_hit_index;
      logic                      idx_hit;
      logic [KEY_PORT_WIDTH-1:0] idx_hit_key;
      logic                      free_hit;
      logic                      after_hit;
      logic [KEY_PORT_WIDTH-1:0] after_key;
      logic [INDEX_WIDTH-1:0]    after_index;
      logic                      first_hit;
      logic [KEY_PORT_WIDTH-1:0] first_key;
      logic [INDEX_WIDTH-1:0]    first_index;
   } scan_result_type;

endpackage

@@ design/ikse_ram.sv @@
module ikse_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ikse_scan.sv @@
module ikse_scan #(
   parameter int SLOT_WIDTH = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            data_valid,
   input  logic [SLOT_WIDTH-1:0]           slot,
   input  logic                            slot_valid,
   input  logic [31:0]                     slot_key,
   input  logic [31:0]                     slot_index,
   input  logic [31:0]                     req_key,
   input  logic [31:0]                     req_index,
   output ikse_pkg::scan_result_type       result,
   output logic [SLOT_WIDTH-1:0]           key_hit_slot,
   output logic [SLOT_WIDTH-1:0]           idx_hit_slot,
   output logic [SLOT_WIDTH-1:0]           free_slot
);

   import ikse_pkg::*;

   scan_result_type       res_ff;
   logic [SLOT_WIDTH-1:0] key_slot_ff;
   logic [SLOT_WIDTH-1:0] idx_slot_ff;
   logic [SLOT_WIDTH-1:0] free_slot_ff;
   logic                  above_req;
   logic                  below_after;
   logic                  below_first;

   assign above_req   = slot_index > req_index;
   assign below_after = slot_index < res_ff.after_index;
   assign below_first = slot_index < res_ff.first_index;

   always_ff @(posedge clock) begin
      if (reset || start) begin
         res_ff.key_hit   <= 1'b0;
         res_ff.idx_hit   <= 1'b0;
         res_ff.free_hit  <= 1'b0;
         res_ff.after_hit <= 1'b0;
         res_ff.first_hit <= 1'b0;
      end else if (data_valid) begin
         if (slot_valid) begin
            if (slot_key == req_key) begin
               res_ff.key_hit       <= 1'b1;
               res_ff.key_hit_index <= slot_index;
               key_slot_ff          <= slot;
            end
            if (slot_index == req_index) begin
               res_ff.idx_hit     <= 1'b1;
               res_ff.idx_hit_key <= slot_key;
               idx_slot_ff        <= slot;
            end
            if (above_req && (!res_ff.after_hit || below_after)) begin
               res_ff.after_hit   <= 1'b1;
               res_ff.after_key   <= slot_key;
               res_ff.after_index <= slot_index;
            end
            if (!res_ff.first_hit || below_first) begin
               res_ff.first_hit   <= 1'b1;
               res_ff.first_key   <= slot_key;
               res_ff.first_index <= slot_index;
            end
         end else if (!res_ff.free_hit) begin
            res_ff.free_hit <= 1'b1;
            free_slot_ff    <= slot;
         end
      end
   end

   assign result       = res_ff;
   assign key_hit_slot = key_slot_ff;
   assign idx_hit_slot = idx_slot_ff;
   assign free_slot    = free_slot_ff;

endmodule

@@ design/indexed_key_set_engine.sv @@
// Indexed key set engine: a store of up to CAPACITY distinct nonzero keys, each
// tagged with an index from a monotonic counter. A request word on the req_
// channel (kind, key, index) is taken when req_valid is high and req_stall is
// low; one response word (status, key, index, entry count) leaves on rsp_.
// Every request scans all slots of the slot memory through one read port, one
// slot per cycle, into a shared compare unit; it then commits any write and
// loads the response register. After accept the block steps through ST_SCAN,
// ST_DRAIN and ST_FINISH, raises rsp_valid when it commits in ST_FINISH and
// returns to ST_IDLE, the only state in which a new request is accepted.
// After reset the block clears the slot memory, one slot per cycle, with
// req_stall high. The response register frees the request side: a new
// request is accepted while a response still waits. If rsp_stall holds the
// previous response until the next one is ready, the block waits in its final
// step and commits only once the old response has been taken.
module indexed_key_set_engine #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_key_in,
   input  logic [31:0] req_index_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_key_out,
   output logic [31:0] rsp_index_out,
   output logic [6:0]  rsp_entry_count
);

   import ikse_pkg::*;

   localparam int AW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int SKW    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
   localparam int WORD_W = 1 + SKW + INDEX_WIDTH;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     cnt_ff;
   logic              data_valid_ff;
   logic [AW-1:0]     slot_ff;
   kind_type          kind_ff;
   logic [31:0]       key_ff;
   logic [31:0]       idx_ff;
   logic [31:0]       next_free_ff;
   logic [CW-1:0]     count_ff;
   logic              rsp_valid_ff;
   logic [1:0]        status_ff;
   logic [31:0]       key_out_ff;
   logic [31:0]       index_out_ff;
   logic [6:0]        entry_count_ff;

   logic              accept;
   logic              last;
   logic              commit;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic [WORD_W-1:0] rd_word;
   logic              rd_valid_bit;
   logic [31:0]       rd_key;
   logic [31:0]       rd_index;

   scan_result_type   scan;
   logic [AW-1:0]     key_hit_slot;
   logic [AW-1:0]     idx_hit_slot;
   logic [AW-1:0]     free_slot;

   logic [1:0]        status_in;
   logic [31:0]       key_out_in;
   logic [31:0]       index_out_in;
   logic              wr_req;
   logic [AW-1:0]     wr_slot;
   logic [WORD_W-1:0] wr_word;
   logic              advance;
   logic              remove;
   logic [CW-1:0]     count_in;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign last      = (cnt_ff == AW'(CAPACITY - 1));
   assign commit    = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign rd_valid_bit = rd_word[WORD_W-1];
   assign rd_key       = 32'(rd_word[INDEX_WIDTH +: SKW]);
   assign rd_index     = rd_word[INDEX_WIDTH-1:0];

   assign mem_wr_en   = (state_ff == ST_CLEAR) || (commit && wr_req);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? cnt_ff : wr_slot;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : wr_word;

   ikse_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (cnt_ff),
      .rd_data (rd_word)
   );

   ikse_scan #(
      .SLOT_WIDTH (AW)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .data_valid   (data_valid_ff),
      .slot         (slot_ff),
      .slot_valid   (rd_valid_bit),
      .slot_key     (rd_key),
      .slot_index   (rd_index),
      .req_key      (key_ff),
      .req_index    (idx_ff),
      .result       (scan),
      .key_hit_slot (key_hit_slot),
      .idx_hit_slot (idx_hit_slot),
      .free_slot    (free_slot)
   );

   always_comb begin
      status_in    = STATUS_NOT_FOUND;
      key_out_in   = '0;
      index_out_in = '1;
      wr_req       = 1'b0;
      wr_slot      = free_slot;
      wr_word      = {1'b1, SKW'(key_ff), next_free_ff};
      advance      = 1'b0;
      remove       = 1'b0;
      case (kind_ff)
         KIND_PUT: begin
            if (key_ff == '0) begin
               status_in = STATUS_NOT_FOUND;
            end else if (scan.key_hit) begin
               status_in    = STATUS_DUPLICATE;
               key_out_in   = key_ff;
               index_out_in = scan.key_hit_index;
            end else if (!scan.free_hit || (next_free_ff == '1)) begin
               status_in = STATUS_FULL;
            end else begin
               status_in    = STATUS_OK;
               key_out_in   = key_ff;
               index_out_in = next_free_ff;
               wr_req       = 1'b1;
               advance      = 1'b1;
            end
         end
         KIND_GET_INDEX: begin
            if (scan.idx_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = scan.idx_hit_key;
               index_out_in = idx_ff;
            end
         end
         KIND_GET_KEY: begin
            if ((key_ff != '0) && scan.key_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = key_ff;
               index_out_in = scan.key_hit_index;
            end
         end
         KIND_REMOVE_INDEX: begin
            if (scan.idx_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = scan.idx_hit_key;
               index_out_in = idx_ff;
               wr_req       = 1'b1;
               wr_slot      = idx_hit_slot;
               wr_word      = '0;
               remove       = 1'b1;
            end
         end
         KIND_REMOVE_KEY: begin
            if ((key_ff != '0) && scan.key_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = key_ff;
               index_out_in = scan.key_hit_index;
               wr_req       = 1'b1;
               wr_slot      = key_hit_slot;
               wr_word      = '0;
               remove       = 1'b1;
            end
         end
         KIND_FIRST: begin
            if (scan.first_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = scan.first_key;
               index_out_in = scan.first_index;
            end
         end
         KIND_NEXT: begin
            if (scan.idx_hit && scan.after_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = scan.after_key;
               index_out_in = scan.after_index;
            end
         end
         KIND_ROUND_ROBIN: begin
            if (scan.idx_hit && scan.after_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = scan.after_key;
               index_out_in = scan.after_index;
            end else if (scan.first_hit) begin
               status_in    = STATUS_OK;
               key_out_in   = scan.first_key;
               index_out_in = scan.first_index;
            end
         end
         default: begin
            status_in = STATUS_NOT_FOUND;
         end
      endcase
      if (advance) begin
         count_in = count_ff + CW'(1);
      end else if (remove) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         data_valid_ff <= 1'b0;
         next_free_ff  <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         data_valid_ff <= (state_ff == ST_SCAN);
         slot_ff       <= cnt_ff;
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  kind_ff  <= kind_type'(req_kind);
                  key_ff   <= 32'(SKW'(req_key_in));
                  idx_ff   <= req_index_in;
                  cnt_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (commit) begin
                  if (advance) begin
                     next_free_ff <= next_free_ff + 32'd1;
                  end
                  count_ff       <= count_in;
                  status_ff      <= status_in;
                  key_out_ff     <= key_out_in;
                  index_out_ff   <= index_out_in;
                  entry_count_ff <= 7'(count_in);
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_index_out   = index_out_ff;
   assign rsp_entry_count = entry_count_ff;

`include "indexed_key_set_engine_assert.svh"

   `IKSE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `IKSE_ASSERT_NEXT(a_put_counts, clock, reset,
      commit && (kind_ff == KIND_PUT) && (status_in == STATUS_OK),
      count_ff == $past(count_ff) + CW'(1))
   `IKSE_ASSERT_SAME(a_full_empty_payload, clock, reset,
      rsp_valid && (rsp_status == STATUS_FULL),
      (rsp_key_out == '0) && (rsp_index_out == '1))
   `IKSE_ASSERT_SAME(a_stall_outside_idle, clock, reset,
      commit, !rsp_valid_ff || !rsp_stall)

endmodule

@@ tb/tb_indexed_key_set_engine.sv @@
module tb_indexed_key_set_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import ikse_pkg::*;

   localparam int CAPACITY = 64;
   localparam logic [31:0] NO_INDEX = 32'hFFFF_FFFF;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] index;
      logic [6:0]  count;
   } rsp_word_type;

   class key_set_scoreboard;
      bit           slot_used [CAPACITY];
      bit [31:0]    slot_key [CAPACITY];
      bit [31:0]    slot_index [CAPACITY];
      bit [31:0]    next_index;
      int unsigned  live_count;
      rsp_word_type expected_q [$];
      int unsigned  errors;
      int unsigned  checked;
      int unsigned  n_dup;
      int unsigned  n_full;
      int unsigned  n_missing;

      function int find_key(bit [31:0] key);
         for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && slot_key[i] == key) return i;
         return -1;
      endfunction

      function int find_index(bit [31:0] idx);
         for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && slot_index[i] == idx) return i;
         return -1;
      endfunction

      function int find_after(bit [31:0] lo, bit strict);
         int best;
         best = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (!slot_used[i]) continue;
            if (strict && slot_index[i] <= lo) continue;
            if (best < 0 || slot_index[i] < slot_index[best]) best = i;
         end
         return best;
      endfunction

      function rsp_word_type slot_word(logic [1:0] status, int s);
         rsp_word_type w;
         if (s < 0) begin
            w.status = STATUS_NOT_FOUND;
            w.key    = '0;
            w.index  = NO_INDEX;
         end else begin
            w.status = status;
            w.key    = slot_key[s];
            w.index  = slot_index[s];
         end
         w.count = live_count[6:0];
         return w;
      endfunction

      function int pick_live();
         int live [$];
         for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i]) live.push_back(i);
         if (live.size() == 0) return -1;
         return live[$urandom_range(0, live.size() - 1)];
      endfunction

      function void note_request(kind_type kind, bit [31:0] key, bit [31:0] idx);
         rsp_word_type w;
         int s;
         int f;
         case (kind)
            KIND_PUT: begin
               s = (key == 0) ? -1 : find_key(key);
               if (key == 0) begin
                  w = slot_word(STATUS_NOT_FOUND, -1);
               end else if (s >= 0) begin
                  w = slot_word(STATUS_DUPLICATE, s);
               end else begin
                  f = -1;
                  for (int i = CAPACITY - 1; i >= 0; i--)
                     if (!slot_used[i]) f = i;
                  if (f < 0 || next_index == NO_INDEX) begin
                     w = slot_word(STATUS_NOT_FOUND, -1);
                     w.status = STATUS_FULL;
                  end else begin
                     slot_used[f]  = 1'b1;
                     slot_key[f]   = key;
                     slot_index[f] = next_index;
                     next_index++;
                     live_count++;
                     w = slot_word(STATUS_OK, f);
                  end
               end
            end
            KIND_GET_INDEX: w = slot_word(STATUS_OK, find_index(idx));
            KIND_GET_KEY:   w = slot_word(STATUS_OK, (key == 0) ? -1 : find_key(key));
            KIND_REMOVE_INDEX, KIND_REMOVE_KEY: begin
               if (kind == KIND_REMOVE_INDEX) s = find_index(idx);
               else s = (key == 0) ? -1 : find_key(key);
               if (s >= 0) begin
                  slot_used[s] = 1'b0;
                  live_count--;
               end
               w = slot_word(STATUS_OK, s);
            end
            KIND_FIRST: w = slot_word(STATUS_OK, find_after('0, 1'b0));
            KIND_NEXT: begin
               s = find_index(idx);
               w = slot_word(STATUS_OK, (s < 0) ? -1 : find_after(idx, 1'b1));
            end
            default: begin
               s = find_index(idx);
               f = (s < 0) ? -1 : find_after(idx, 1'b1);
               if (f < 0) f = find_after('0, 1'b0);
               w = slot_word(STATUS_OK, f);
            end
         endcase
         expected_q.push_back(w);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [1:0] status, logic [31:0] key,
                                 logic [31:0] index, logic [6:0] count);
         rsp_word_type w;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response word with none expected: status %0d key %h index %h",
                     $time, status, key, index);
            return;
         end
         w = expected_q.pop_front();
         checked++;
         if (w.status == STATUS_DUPLICATE) n_dup++;
         if (w.status == STATUS_FULL) n_full++;
         if (w.status == STATUS_NOT_FOUND) n_missing++;
         compare_field("status", w.status, status);
         compare_field("key_out", w.key, key);
         compare_field("index_out", w.index, index);
         compare_field("entry_count", w.count, count);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = KIND_PUT;
   logic [31:0] req_key_in = '0;
   logic [31:0] req_index_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_key_out;
   logic [31:0] rsp_index_out;
   logic [6:0]  rsp_entry_count;

   bit                steady;
   bit [31:0]         key_pool [8];
   key_set_scoreboard sb;

   indexed_key_set_engine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_key_in(req_key_in),
      .req_index_in(req_index_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_key_out(rsp_key_out),
      .rsp_index_out(rsp_index_out),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 31);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_key_out, rsp_index_out, rsp_entry_count);
   end

   task automatic send_word(kind_type kind, bit [31:0] key, bit [31:0] idx);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_key_in   <= key;
      req_index_in <= idx;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, key, idx);
      @(negedge clock);
   endtask

   function automatic bit [31:0] pick_key(int unsigned live_pct);
      int unsigned r;
      int s;
      r = $urandom_range(0, 99);
      s = sb.pick_live();
      if (r < 5) return '0;
      if (r < 5 + live_pct && s >= 0) return sb.slot_key[s];
      if (r < 20 + live_pct) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic bit [31:0] pick_index();
      int unsigned r;
      int s;
      r = $urandom_range(0, 99);
      s = sb.pick_live();
      if (r < 55 && s >= 0) return sb.slot_index[s];
      if (r < 65) return sb.next_index;
      if (r < 75) return sb.next_index - 1;
      if (r < 80) return NO_INDEX;
      return $urandom;
   endfunction

   task automatic random_words(int unsigned count, int unsigned put_pct,
                               int unsigned remove_pct);
      int unsigned r;
      kind_type    kind;
      kind_type    lookups [5];
      lookups = '{KIND_GET_INDEX, KIND_GET_KEY, KIND_FIRST, KIND_NEXT, KIND_ROUND_ROBIN};
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < put_pct) kind = KIND_PUT;
         else if (r < put_pct + remove_pct)
            kind = $urandom_range(0, 1) ? KIND_REMOVE_INDEX : KIND_REMOVE_KEY;
         else kind = lookups[$urandom_range(0, 4)];
         send_word(kind, pick_key(kind == KIND_PUT ? 20 : 55), pick_index());
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb = new();
      foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(KIND_FIRST, '0, '0);
      send_word(KIND_ROUND_ROBIN, '0, '0);
      send_word(KIND_PUT, '0, '0);
      send_word(KIND_PUT, 32'hFFFF_FFFF, '0);
      send_word(KIND_PUT, 32'h1, '0);
      send_word(KIND_PUT, 32'h8000_0000, '0);
      send_word(KIND_PUT, 32'h1, '0);
      send_word(KIND_GET_INDEX, '0, 32'd1);
      send_word(KIND_GET_INDEX, '0, NO_INDEX);
      send_word(KIND_GET_KEY, 32'hFFFF_FFFF, '0);
      send_word(KIND_GET_KEY, '0, '0);
      send_word(KIND_GET_KEY, 32'h1234, '0);
      send_word(KIND_FIRST, '0, NO_INDEX);
      send_word(KIND_NEXT, '0, 32'd0);
      send_word(KIND_NEXT, '0, 32'd2);
      send_word(KIND_NEXT, '0, 32'd7);
      send_word(KIND_ROUND_ROBIN, '0, 32'd2);
      send_word(KIND_ROUND_ROBIN, '0, NO_INDEX);
      send_word(KIND_ROUND_ROBIN, '0, 32'd0);
      send_word(KIND_REMOVE_INDEX, '0, 32'd1);
      send_word(KIND_REMOVE_INDEX, '0, 32'd1);
      send_word(KIND_REMOVE_KEY, '0, '0);
      send_word(KIND_REMOVE_KEY, 32'h8000_0000, '0);
      send_word(KIND_REMOVE_KEY, 32'h8000_0000, '0);
      send_word(KIND_PUT, 32'h1, '0);

      random_words(180, 85, 0);
      random_words(120, 35, 25);
      wait_drained();
      steady = 1'b1;
      random_words(100, 30, 30);
      steady = 1'b0;
      random_words(150, 10, 55);
      random_words(150, 45, 20);

      wait_drained();
      repeat (CAPACITY + 8) @(posedge clock);
      $display("Checked %0d response words: %0d duplicate puts, %0d puts on a full table,",
               sb.checked, sb.n_dup, sb.n_full);
      $display("%0d misses on zero keys or absent entries, %0d entries left in the set.",
               sb.n_missing, sb.live_count);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d response words outstanding.", sb.expected_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/ikse_pkg.sv
design/ikse_ram.sv
design/ikse_scan.sv
design/indexed_key_set_engine.sv
tb/tb_indexed_key_set_engine.sv
